[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define CDQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/cdq_pkg.sv]
package cdq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;

    typedef logic [1:0]                t_action;
    typedef logic [1:0]                t_status;
    typedef logic signed [VALUE_W-1:0] t_value;

    localparam t_action ACT_PUSH_BACK  = 2'd0;
    localparam t_action ACT_PUSH_FRONT = 2'd1;
    localparam t_action ACT_POP_BACK   = 2'd2;
    localparam t_action ACT_POP_FRONT  = 2'd3;

    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // Per-request outcome handed from the pointer control to the result stage.
    typedef struct packed {
        t_status status;
        logic    pop_ok;
        logic    now_empty;
        logic    now_full;
    } t_res_ctl;

endpackage

[rtl/cdq_if.sv]
interface cdq_in_if;
    logic             valid;
    logic             ready;
    cdq_pkg::t_action action;
    cdq_pkg::t_value  push_value;

    modport source (output valid, output action, output push_value, input ready);
    modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface cdq_out_if #(
    parameter int COUNT_W = 5
);
    logic               valid;
    logic               ready;
    cdq_pkg::t_value    pop_value;
    cdq_pkg::t_status   status;
    logic               now_empty;
    logic               now_full;
    logic [COUNT_W-1:0] occupancy;

    modport source (output valid, output pop_value, output status, output now_empty,
                    output now_full, output occupancy, input ready);
    modport sink   (input valid, input pop_value, input status, input now_empty,
                    input now_full, input occupancy, output ready);
endinterface

[rtl/cdq_store.sv]
module cdq_store #(
    parameter int DEPTH  = cdq_pkg::DEPTH_DEFAULT,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_addr,
    input  cdq_pkg::t_value   i_wr_data,
    output cdq_pkg::t_value   o_rd_data
);

    cdq_pkg::t_value r_mem [DEPTH];
    cdq_pkg::t_value r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/cdq_ctrl.sv]
module cdq_ctrl #(
    parameter int DEPTH   = cdq_pkg::DEPTH_DEFAULT,
    parameter int ADDR_W  = $clog2(DEPTH),
    parameter int COUNT_W = $clog2(DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  cdq_pkg::t_action   i_action,
    output logic               o_wr_en,
    output logic               o_rd_en,
    output logic [ADDR_W-1:0]  o_addr,
    output cdq_pkg::t_res_ctl  o_res,
    output logic [COUNT_W-1:0] o_count
);

    localparam logic [ADDR_W-1:0]  LastIdx   = ADDR_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] FullCount = COUNT_W'(DEPTH);

    logic [ADDR_W-1:0]  r_front, n_front;
    logic [ADDR_W-1:0]  r_back, n_back;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [ADDR_W-1:0]  front_up, front_dn, back_up, back_dn;
    logic               is_full, is_empty, wr, rd;

    assign is_full  = (r_count == FullCount);
    assign is_empty = (r_count == '0);
    assign front_up = (r_front == LastIdx) ? '0 : r_front + 1'b1;
    assign front_dn = (r_front == '0) ? LastIdx : r_front - 1'b1;
    assign back_up  = (r_back == LastIdx) ? '0 : r_back + 1'b1;
    assign back_dn  = (r_back == '0) ? LastIdx : r_back - 1'b1;

    always_comb begin
        n_front      = r_front;
        n_back       = r_back;
        n_count      = r_count;
        wr           = 1'b0;
        rd           = 1'b0;
        o_addr       = r_back;
        o_res.status = cdq_pkg::ST_DONE;
        o_res.pop_ok = 1'b0;
        unique case (i_action)
            cdq_pkg::ACT_PUSH_BACK: begin
                if (is_full) begin
                    o_res.status = cdq_pkg::ST_FULL;
                end else begin
                    wr      = 1'b1;
                    o_addr  = r_back;
                    n_back  = back_up;
                    n_count = r_count + 1'b1;
                end
            end
            cdq_pkg::ACT_PUSH_FRONT: begin
                if (is_full) begin
                    o_res.status = cdq_pkg::ST_FULL;
                end else begin
                    wr      = 1'b1;
                    o_addr  = front_dn;
                    n_front = front_dn;
                    n_count = r_count + 1'b1;
                end
            end
            cdq_pkg::ACT_POP_BACK: begin
                if (is_empty) begin
                    o_res.status = cdq_pkg::ST_EMPTY;
                end else begin
                    rd           = 1'b1;
                    o_addr       = back_dn;
                    n_back       = back_dn;
                    n_count      = r_count - 1'b1;
                    o_res.pop_ok = 1'b1;
                end
            end
            cdq_pkg::ACT_POP_FRONT: begin
                if (is_empty) begin
                    o_res.status = cdq_pkg::ST_EMPTY;
                end else begin
                    rd           = 1'b1;
                    o_addr       = r_front;
                    n_front      = front_up;
                    n_count      = r_count - 1'b1;
                    o_res.pop_ok = 1'b1;
                end
            end
            default: begin
                o_res.status = cdq_pkg::ST_DONE;
            end
        endcase
        o_res.now_empty = (n_count == '0);
        o_res.now_full  = (n_count == FullCount);
    end

    assign o_wr_en = i_accept && wr;
    assign o_rd_en = i_accept && rd;
    assign o_count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

endmodule

[rtl/circular_deque.sv]
// Double-ended queue on a circular buffer of DEPTH slots.
// i_req carries one request per handshake: an action (push back, push front,
// pop back, pop front) and a signed 32-bit value used by the pushes.
// o_res returns exactly one result per request, in request order: the popped
// value (zero unless a pop succeeded), a status (done, pop refused because
// empty, push refused because full), the empty and full flags and the
// occupancy after the request.
// A result is registered and valid in the cycle after its request is taken.
// Throughput: one request per cycle while the result is not stalled. Pointers and the count update in the
// accept cycle and the slot memory takes at most one write or one read per request,
// so back-to-back requests never wait on each other.
// Stall: a single output register holds the result while o_res.ready is low;
// i_req.ready then follows o_res.ready, so a new request enters in the same
// cycle the held result leaves.
// Reset: synchronous, active low; empties the deque (pointers and count to
// zero) and drops any pending result. Slot contents are not cleared and need
// no clearing pass, since a pop only reads slots that hold entries.
`include "assert_macros.svh"

module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cdq_in_if.sink    i_req,
    cdq_out_if.source o_res
);

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam logic [COUNT_W-1:0] FullCount = COUNT_W'(DEPTH);

    // Result register state, held while the receiver stalls.
    logic                 r_out_valid;
    cdq_pkg::t_res_ctl    r_out_ctl;
    logic [COUNT_W-1:0]   r_out_count;

    // Request handshake: take a request when the output slot is free or drains now.
    logic accept;
    assign i_req.ready = !r_out_valid || o_res.ready;
    assign accept      = i_req.valid && i_req.ready;

    // Pointer and count control.
    logic                 mem_wr, mem_rd;
    logic [ADDR_W-1:0]    mem_addr;
    cdq_pkg::t_res_ctl    res_ctl;
    logic [COUNT_W-1:0]   res_count;
    cdq_pkg::t_value      rd_data;

    cdq_ctrl #(
        .DEPTH   (DEPTH),
        .ADDR_W  (ADDR_W),
        .COUNT_W (COUNT_W)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_action (i_req.action),
        .o_wr_en  (mem_wr),
        .o_rd_en  (mem_rd),
        .o_addr   (mem_addr),
        .o_res    (res_ctl),
        .o_count  (res_count)
    );

    // Slot memory: at most one access per request, read data lands with the result register.
    // A pop right after a push to the same slot reads it after the write has landed,
    // so the stored value is already there.
    cdq_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr),
        .i_rd_en   (mem_rd),
        .i_addr    (mem_addr),
        .i_wr_data (i_req.push_value),
        .o_rd_data (rd_data)
    );

    // Result register. The memory read register only loads on an accepted pop,
    // so it holds along with these while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_ctl   <= res_ctl;
            r_out_count <= res_count;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.pop_value = r_out_ctl.pop_ok ? rd_data : '0;
    assign o_res.status    = r_out_ctl.status;
    assign o_res.now_empty = r_out_ctl.now_empty;
    assign o_res.now_full  = r_out_ctl.now_full;
    assign o_res.occupancy = r_out_count;

    // Checks on the result stage.
    `CDQ_ASSERT(a_accept_gives_result, i_clk, i_rst_n, accept |=> o_res.valid, "request taken without a result next cycle")
    `CDQ_ASSERT(a_count_in_range, i_clk, i_rst_n, o_res.valid |-> (r_out_count <= FullCount), "occupancy above depth")
    `CDQ_ASSERT(a_empty_flag, i_clk, i_rst_n, o_res.valid |-> (r_out_ctl.now_empty == (r_out_count == '0)), "empty flag disagrees with occupancy")
    `CDQ_ASSERT(a_full_refusal, i_clk, i_rst_n, (o_res.valid && (o_res.status == cdq_pkg::ST_FULL)) |-> o_res.now_full, "push refused while not full")

endmodule
